// ===== src/pqz_pkg.sv =====
// palette color quantizer: shared constants, state encoding and control structs
// used by pqz_div, pqz_dp, pqz_ctrl and the top level; depends on nothing
`default_nettype none
package pqz_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_PIXELS    = 262144;

	localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
	localparam int SCAN_W   = PAL_AW + 1;
	localparam int SCAN_NIB = (PALETTE_DEPTH < 16) ? PALETTE_DEPTH : 16;
	localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
	localparam int TOTAL_W  = 29;
	localparam int DIFF_W   = 11;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [DIFF_W-1:0]  DIFF_MAX  = '1;

	// floor(x / 65025) == (x * RECIP_M) >> RECIP_SH for x < 2^24
	localparam logic [24:0] RECIP_M  = 25'd16909061;
	localparam int          RECIP_SH = 40;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MATCH = 1'b1;
	localparam logic BPP_4     = 1'b0;
	localparam logic BPP_8     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start_pixel;
		logic write_pal;
		logic issue;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic pipe_busy;
		logic div_busy;
		logic last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/pqz_ram.sv =====
// generic single-write, single-read memory with registered read data
// no package dependency
`default_nettype none
module pqz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/pqz_div.sv =====
// restoring divider, one quotient bit per cycle, for the mean distance
// depends on pqz_pkg
`default_nettype none
module pqz_div import pqz_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TOTAL_W-1:0] num,
	input  wire logic [CNT_W-1:0]   den,
	output logic                    busy,
	output logic      [TOTAL_W-1:0] quot
);

	localparam int STEP_W = $clog2(TOTAL_W);

	logic [TOTAL_W-1:0] num_q;
	logic [CNT_W-1:0]   den_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic [CNT_W:0]     rem_sh;
	logic [CNT_W:0]     rem_sub;
	logic               qbit;

	always_comb begin
		rem_sh  = {rem_q, num_q[TOTAL_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(TOTAL_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TOTAL_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule
`default_nettype wire

// ===== src/pqz_dp.sv =====
// datapath: palette memory, distance pipeline, best-match tracking,
// nibble packing, image statistics and result register; uses pqz_ram, pqz_div, pqz_pkg
`default_nettype none
module pqz_dp import pqz_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           ctl,
	output dp_stat_t               stat,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic [7:0]        entry_index,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic [7:0]        alpha,
	input  wire logic              last_pixel,
	output logic      [7:0]        palette_index,
	output logic      [DIFF_W-1:0] match_diff,
	output logic      [7:0]        packed_byte,
	output logic                   byte_valid,
	output logic                   image_done,
	output logic      [DIFF_W-1:0] max_diff,
	output logic      [DIFF_W-1:0] avg_diff
);

	function automatic logic [15:0] absdiff16(input logic [15:0] x, input logic [15:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

	logic bpp_q;
	logic phase_q;
	logic [3:0] held_q;

	logic [15:0] ca_r_q, ca_g_q, ca_b_q;
	logic [7:0]  alpha_q;
	logic        last_q;

	logic [SCAN_W-1:0] scan_q;
	logic [SCAN_W-1:0] scan_last;

	logic        pal_we;
	logic [31:0] ent;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [PAL_AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [7:0]        ad_s2, ad_s3, ad_s4, ad_s5;
	logic [15:0]       pp_r_s2, pp_g_s2, pp_b_s2;
	logic [15:0]       abs_r_s3, abs_g_s3, abs_b_s3;
	logic [23:0]       wt_r_s4, wt_g_s4, wt_b_s4;
	logic [7:0]        q_r_s5, q_g_s5, q_b_s5;

	logic [7:0]  pa, ad_s1;
	logic [48:0] qp_r, qp_g, qp_b;
	logic [DIFF_W-1:0] dsum;

	logic [PAL_AW-1:0] best_q;
	logic [DIFF_W-1:0] range_q;
	logic [7:0]        best8;

	logic [DIFF_W-1:0]  worst_q, worst_nx;
	logic [TOTAL_W-1:0] total_q, total_nx;
	logic [TOTAL_W:0]   total_sum;
	logic [CNT_W-1:0]   count_q, count_nx;

	logic [7:0]  byte_nx;
	logic        bv_nx;
	logic        phase_nx;
	logic [3:0]  held_nx;

	logic [7:0]        res_idx_q, res_byte_q;
	logic [DIFF_W-1:0] res_diff_q, res_max_q;
	logic              res_bv_q, res_last_q;

	logic               div_busy;
	logic [TOTAL_W-1:0] quot;
	logic [DIFF_W-1:0]  avg_sat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_8;
		end else if (cfg_we) begin
			bpp_q <= cfg_wdata;
		end
	end

	// pixel capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (ctl.start_pixel) begin
			last_q <= last_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_pixel) begin
			ca_r_q  <= 16'(red) * 16'(alpha);
			ca_g_q  <= 16'(green) * 16'(alpha);
			ca_b_q  <= 16'(blue) * 16'(alpha);
			alpha_q <= alpha;
		end
	end

	// scan address counter
	assign scan_last = (bpp_q == BPP_8) ? SCAN_W'(PALETTE_DEPTH - 1) : SCAN_W'(SCAN_NIB - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.start_pixel) begin
			scan_q <= '0;
		end else if (ctl.issue) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	assign pal_we = ctl.write_pal && ({1'b0, entry_index} < 9'(PALETTE_DEPTH));

	pqz_ram #(
		.WIDTH (32),
		.DEPTH (PALETTE_DEPTH)
	) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (entry_index[PAL_AW-1:0]),
		.wdata ({alpha, blue, green, red}),
		.raddr (scan_q[PAL_AW-1:0]),
		.rdata (ent)
	);

	// distance pipeline
	always_comb begin
		pa    = ent[31:24];
		ad_s1 = (alpha_q > pa) ? (alpha_q - pa) : (pa - alpha_q);
		qp_r  = 49'(wt_r_s4) * 49'(RECIP_M);
		qp_g  = 49'(wt_g_s4) * 49'(RECIP_M);
		qp_b  = 49'(wt_b_s4) * 49'(RECIP_M);
		dsum  = DIFF_W'({ad_s5, 2'b00}) + DIFF_W'(q_r_s5) + DIFF_W'(q_g_s5) + DIFF_W'(q_b_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[PAL_AW-1:0];

		idx_s2  <= idx_s1;
		ad_s2   <= ad_s1;
		pp_r_s2 <= 16'(ent[7:0]) * 16'(pa);
		pp_g_s2 <= 16'(ent[15:8]) * 16'(pa);
		pp_b_s2 <= 16'(ent[23:16]) * 16'(pa);

		idx_s3   <= idx_s2;
		ad_s3    <= ad_s2;
		abs_r_s3 <= absdiff16(ca_r_q, pp_r_s2);
		abs_g_s3 <= absdiff16(ca_g_q, pp_g_s2);
		abs_b_s3 <= absdiff16(ca_b_q, pp_b_s2);

		idx_s4  <= idx_s3;
		ad_s4   <= ad_s3;
		wt_r_s4 <= 24'(abs_r_s3) * 24'(8'd255 - ad_s3);
		wt_g_s4 <= 24'(abs_g_s3) * 24'(8'd255 - ad_s3);
		wt_b_s4 <= 24'(abs_b_s3) * 24'(8'd255 - ad_s3);

		idx_s5 <= idx_s4;
		ad_s5  <= ad_s4;
		q_r_s5 <= qp_r[RECIP_SH+7:RECIP_SH];
		q_g_s5 <= qp_g[RECIP_SH+7:RECIP_SH];
		q_b_s5 <= qp_b[RECIP_SH+7:RECIP_SH];
	end

	// best match, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (ctl.start_pixel) begin
			best_q  <= '0;
			range_q <= DIFF_MAX;
		end else if (valid_s5 && (dsum < range_q)) begin
			best_q  <= idx_s5;
			range_q <= dsum;
		end
	end

	assign best8 = 8'(best_q);

	// statistics and nibble packing
	always_comb begin
		worst_nx  = (range_q > worst_q) ? range_q : worst_q;
		total_sum = {1'b0, total_q} + (TOTAL_W+1)'(range_q);
		total_nx  = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
		count_nx  = (count_q < CNT_W'(MAX_PIXELS)) ? (count_q + 1'b1) : count_q;

		byte_nx  = '0;
		bv_nx    = 1'b0;
		phase_nx = phase_q;
		held_nx  = held_q;
		if (bpp_q == BPP_8) begin
			byte_nx = best8;
			bv_nx   = 1'b1;
		end else if (!phase_q) begin
			held_nx  = best8[3:0];
			phase_nx = 1'b1;
			if (last_q) begin
				byte_nx = {4'd0, best8[3:0]};
				bv_nx   = 1'b1;
			end
		end else begin
			byte_nx  = {best8[3:0], held_q};
			bv_nx    = 1'b1;
			phase_nx = 1'b0;
			held_nx  = '0;
		end
		if (last_q) begin
			phase_nx = 1'b0;
			held_nx  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			held_q  <= '0;
			worst_q <= '0;
			total_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			phase_q <= 1'b0;
			held_q  <= '0;
		end else if (ctl.commit) begin
			phase_q <= phase_nx;
			held_q  <= held_nx;
			if (last_q) begin
				worst_q <= '0;
				total_q <= '0;
				count_q <= '0;
			end else begin
				worst_q <= worst_nx;
				total_q <= total_nx;
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			res_idx_q  <= best8;
			res_diff_q <= range_q;
			res_byte_q <= byte_nx;
			res_bv_q   <= bv_nx;
			res_last_q <= last_q;
			res_max_q  <= last_q ? worst_nx : '0;
		end
	end

	pqz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.commit && last_q),
		.num    (total_nx),
		.den    (count_nx),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign avg_sat = (|quot[TOTAL_W-1:DIFF_W]) ? DIFF_MAX : quot[DIFF_W-1:0];

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			palette_index <= res_idx_q;
			match_diff    <= res_diff_q;
			packed_byte   <= res_byte_q;
			byte_valid    <= res_bv_q;
			image_done    <= res_last_q;
			max_diff      <= res_max_q;
			avg_diff      <= res_last_q ? avg_sat : '0;
		end
	end

	always_comb begin
		stat.issue_last = (scan_q == scan_last);
		stat.pipe_busy  = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5;
		stat.div_busy   = div_busy;
		stat.last       = last_q;
	end

endmodule
`default_nettype wire

// ===== src/pqz_ctrl.sv =====
// controller: sequences accept, palette scan, commit, mean division and result hand-off
// depends on pqz_pkg
`default_nettype none
module pqz_ctrl import pqz_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     cmd,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output logic          in_stall,
	output logic          out_valid,
	output dp_cmd_t       ctl
);

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cmd == CMD_MATCH) begin
						ctl.start_pixel = 1'b1;
						state_nx        = ST_SCAN;
					end else begin
						ctl.write_pal = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				ctl.issue = 1'b1;
				if (stat.issue_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_nx = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_nx   = stat.last ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/palette_color_quantizer_unit.sv =====
// Nearest palette color quantizer, top level.
// Input channel (in_valid / in_stall): cmd 0 writes palette entry entry_index
// with red, green, blue, alpha; cmd 1 matches one RGBA pixel, last_pixel closes
// the image. Output channel (out_valid / out_stall): one item per pixel with the
// best index, its distance, the packed data byte and, on the last pixel, the
// image maximum and mean distance. cfg_we / cfg_wdata set bpp_mode; the user
// must do so only while idle, which the block does not enforce. A pixel scans
// 16 entries in 4-bit mode and 256 in 8-bit mode; the palette memory delivers
// one entry per cycle into a five-stage distance pipeline. The last pixel of an
// image also passes through the bit-serial mean divider.
// One pixel is in work at a time; the next item is accepted as soon as the
// result sits in the output register, even while that result is stalled.
// A stalled output holds its item; a finished pixel then waits until the
// output register frees before it is handed over.
// Reset clears the mode to 8-bit, the nibble packer and the statistics; the
// palette memory holds no defined value until written.
// depends on pqz_pkg, pqz_ctrl, pqz_dp
`default_nettype none
module palette_color_quantizer_unit import pqz_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              cmd,
	input  wire logic [7:0]        entry_index,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic [7:0]        alpha,
	input  wire logic              last_pixel,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        palette_index,
	output logic      [DIFF_W-1:0] match_diff,
	output logic      [7:0]        packed_byte,
	output logic                   byte_valid,
	output logic                   image_done,
	output logic      [DIFF_W-1:0] max_diff,
	output logic      [DIFF_W-1:0] avg_diff
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	pqz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	pqz_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.last_pixel    (last_pixel),
		.palette_index (palette_index),
		.match_diff    (match_diff),
		.packed_byte   (packed_byte),
		.byte_valid    (byte_valid),
		.image_done    (image_done),
		.max_diff      (max_diff),
		.avg_diff      (avg_diff)
	);

endmodule
`default_nettype wire

// ===== src/pqz_checker.sv =====
// port-level checks for the quantizer top level, attached by bind
// depends on palette_color_quantizer_unit
`default_nettype none
module pqz_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        cmd,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  palette_index,
	input wire logic [10:0] match_diff,
	input wire logic [7:0]  packed_byte,
	input wire logic        byte_valid,
	input wire logic        image_done,
	input wire logic [10:0] max_diff,
	input wire logic [10:0] avg_diff
);

	// stalled item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(palette_index) && $stable(match_diff)
			&& $stable(packed_byte) && $stable(byte_valid) && $stable(image_done)
			&& $stable(max_diff) && $stable(avg_diff))
		else $error("output item changed while stalled");

	// a pixel keeps the block busy for its scan
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd |=> in_stall)
		else $error("input accepted during a palette scan");

	a_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !image_done |-> max_diff == 11'd0 && avg_diff == 11'd0)
		else $error("image statistics shown before the last pixel");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> packed_byte == 8'd0)
		else $error("data byte not zero without byte_valid");

endmodule

bind palette_color_quantizer_unit pqz_checker u_pqz_checker (.*);
`default_nettype wire

// ===== sim/tb_palette_color_quantizer_unit.sv =====
// testbench for palette_color_quantizer_unit: loads the palette, runs directed and
// random pixels in both index modes and checks every result against a local predictor
// depends on pqz_pkg and palette_color_quantizer_unit
module tb_palette_color_quantizer_unit import pqz_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 300;

	typedef struct packed {
		logic       op;
		logic [7:0] entry;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} quant_item_t;

	typedef struct packed {
		logic [7:0]        index;
		logic [DIFF_W-1:0] diff;
		logic [7:0]        data_byte;
		logic              byte_ok;
		logic              done;
		logic [DIFF_W-1:0] peak;
		logic [DIFF_W-1:0] mean;
	} quant_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic [7:0] entry_index = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic [7:0] alpha = '0;
	logic last_pixel = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] palette_index;
	logic [DIFF_W-1:0] match_diff;
	logic [7:0] packed_byte;
	logic byte_valid;
	logic image_done;
	logic [DIFF_W-1:0] max_diff;
	logic [DIFF_W-1:0] avg_diff;

	// predictor state
	logic [31:0] pal_copy [0:255];
	logic mode_8bpp = BPP_8;
	logic phase_hi = 1'b0;
	logic [3:0] held_nib = '0;
	logic [DIFF_W-1:0] worst = '0;
	logic [TOTAL_W-1:0] total = '0;
	int unsigned count = 0;

	quant_result_t pending_results [$];
	int errors = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	palette_color_quantizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.entry_index(entry_index),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.palette_index(palette_index),
		.match_diff(match_diff),
		.packed_byte(packed_byte),
		.byte_valid(byte_valid),
		.image_done(image_done),
		.max_diff(max_diff),
		.avg_diff(avg_diff)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned absdiff(int unsigned x, int unsigned y);
		return (x > y) ? x - y : y - x;
	endfunction

	function automatic int unsigned entry_distance(logic [31:0] px, logic [31:0] ent);
		int unsigned a, pa, ad, c, pc, d;
		a = px[31:24];
		pa = ent[31:24];
		ad = absdiff(a, pa);
		d = ad * 4;
		for (int ch = 0; ch < 3; ch++) begin
			c = px[ch*8 +: 8];
			pc = ent[ch*8 +: 8];
			d += absdiff(c * a, pc * pa) * (255 - ad) / 255 / 255;
		end
		return d;
	endfunction

	function automatic quant_result_t quantize_pixel(quant_item_t it);
		quant_result_t res;
		int unsigned span, best, range, d, avg;
		logic [31:0] px;
		px = {it.a, it.b, it.g, it.r};
		span = (mode_8bpp == BPP_8) ? 256 : 16;
		if (span > PALETTE_DEPTH)
			span = PALETTE_DEPTH;
		best = 0;
		range = 32'h7fffffff;
		for (int i = 0; i < span; i++) begin
			d = entry_distance(px, pal_copy[i]);
			if (d < range) begin
				range = d;
				best = i;
			end
		end
		res = '0;
		res.index = best[7:0];
		res.diff = range[DIFF_W-1:0];
		res.done = it.last;
		if (mode_8bpp == BPP_8) begin
			res.data_byte = best[7:0];
			res.byte_ok = 1'b1;
		end else if (!phase_hi) begin
			held_nib = best[3:0];
			phase_hi = 1'b1;
			if (it.last) begin
				res.data_byte = {4'h0, held_nib};
				res.byte_ok = 1'b1;
			end
		end else begin
			res.data_byte = {best[3:0], held_nib};
			res.byte_ok = 1'b1;
			phase_hi = 1'b0;
			held_nib = '0;
		end
		if (range > worst)
			worst = range[DIFF_W-1:0];
		if (longint'(total) + range > longint'(TOTAL_MAX))
			total = TOTAL_MAX;
		else
			total = total + range;
		if (count < MAX_PIXELS)
			count++;
		if (it.last) begin
			avg = total / count;
			res.peak = worst;
			res.mean = (avg > DIFF_MAX) ? DIFF_MAX : avg[DIFF_W-1:0];
			phase_hi = 1'b0;
			held_nib = '0;
			worst = '0;
			total = '0;
			count = 0;
		end
		return res;
	endfunction

	function automatic quant_item_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a, logic last);
		quant_item_t it;
		it = '0;
		it.op = CMD_MATCH;
		it.entry = 8'($urandom_range(255));
		it.r = r;
		it.g = g;
		it.b = b;
		it.a = a;
		it.last = last;
		return it;
	endfunction

	function automatic quant_item_t make_write(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a);
		quant_item_t it;
		it = make_pixel(r, g, b, a, 1'($urandom_range(1)));
		it.op = CMD_WRITE;
		it.entry = idx;
		return it;
	endfunction

	function automatic logic [7:0] random_alpha();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(16)) - 8;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_item(quant_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.op;
		entry_index <= it.entry;
		red <= it.r;
		green <= it.g;
		blue <= it.b;
		alpha <= it.a;
		last_pixel <= it.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.op == CMD_WRITE) begin
			if (it.entry < PALETTE_DEPTH)
				pal_copy[it.entry] = {it.a, it.b, it.g, it.r};
		end else begin
			pending_results.push_back(quantize_pixel(it));
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_mode(logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_8bpp = m;
		phase_hi = 1'b0;
		held_nib = '0;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : result_check
		quant_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: palette_index %0d match_diff %0d",
					palette_index, match_diff);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("palette_index", want.index, palette_index);
				check_field("match_diff", want.diff, match_diff);
				check_field("packed_byte", want.data_byte, packed_byte);
				check_field("byte_valid", want.byte_ok, byte_valid);
				check_field("image_done", want.done, image_done);
				check_field("max_diff", want.peak, max_diff);
				check_field("avg_diff", want.mean, avg_diff);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// every entry gets written so no scan ever reads an unwritten one
	task automatic test_palette_load();
		for (int i = 0; i < 256; i++) begin
			case (i)
				0: send_item(make_write(8'(i), 8'h00, 8'h00, 8'h00, 8'h00));
				1, 2: send_item(make_write(8'(i), 8'hff, 8'hff, 8'hff, 8'hff));
				3: send_item(make_write(8'(i), 8'hff, 8'h00, 8'hff, 8'h80));
				default: send_item(make_write(8'(i), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					(i % 8 == 0) ? 8'h00 : random_alpha()));
			endcase
		end
	endtask

	task automatic test_full_palette_pixels();
		logic [31:0] e;
		e = pal_copy[200];
		send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_item(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
		send_item(make_pixel(e[7:0], e[15:8], e[23:16], e[31:24], 1'b0));
		send_item(make_pixel(8'h00, 8'hff, 8'h00, 8'h7f, 1'b0));
		send_item(make_pixel(8'h12, 8'h34, 8'h56, 8'hff, 1'b1));
	endtask

	task automatic test_nibble_packing();
		drain_results();
		write_mode(BPP_4);
		send_item(make_write(8'd7, 8'h40, 8'h80, 8'hc0, 8'hff));
		send_item(make_write(8'd255, 8'h01, 8'h02, 8'h03, 8'h04));
		// odd pixel count flushes the held nibble
		send_item(make_pixel(8'h40, 8'h80, 8'hc0, 8'hff, 1'b0));
		send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_item(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
		send_item(make_pixel(8'hff, 8'h00, 8'h00, 8'hff, 1'b0));
		send_item(make_pixel(8'h00, 8'h00, 8'hff, 8'h80, 1'b1));
		// mode write drops a held nibble
		send_item(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
		drain_results();
		write_mode(BPP_4);
		send_item(make_pixel(8'h40, 8'h80, 8'hc0, 8'hff, 1'b1));
	endtask

	task automatic run_random_phase(int n, logic m, int idle_pct, int hold_pct);
		logic [31:0] e;
		logic [7:0] idx;
		drain_results();
		write_mode(m);
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				idx = (m == BPP_4 && $urandom_range(1)) ? 8'($urandom_range(15))
					: 8'($urandom_range(255));
				send_item(make_write(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), random_alpha()));
			end else if ($urandom_range(9) < 6) begin
				e = pal_copy[(m == BPP_8) ? $urandom_range(255) : $urandom_range(15)];
				send_item(make_pixel(nudge(e[7:0]), nudge(e[15:8]), nudge(e[23:16]),
					nudge(e[31:24]), $urandom_range(15) == 0));
			end else begin
				send_item(make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), random_alpha(), $urandom_range(15) == 0));
			end
		end
	endtask

	task automatic test_random_traffic();
		int idle_tab [4] = '{0, 87, 0, 24};
		int stall_tab [4] = '{0, 0, 87, 24};
		for (int p = 0; p < 4; p++) begin
			run_random_phase(170, BPP_8, idle_tab[p], stall_tab[p]);
			run_random_phase(170, BPP_4, idle_tab[p], stall_tab[p]);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_palette_load();
		test_full_palette_pixels();
		test_nibble_packing();
		test_random_traffic();
		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
